// ===== rtl/core/ifst_pkg.sv =====
package ifst_pkg;

  localparam int unsigned FlowEntries = 64;
  localparam int unsigned IdxW = $clog2(FlowEntries);
  localparam int unsigned CntW = IdxW + 1;
  localparam int unsigned KeyW = 33;
  localparam int unsigned PktW = 32;
  localparam int unsigned ByteW = 48;
  localparam int unsigned AvgW = 24;
  localparam int unsigned RowW = KeyW + PktW + ByteW;
  localparam int unsigned QDepth = 2;

  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;

  localparam logic CmdPacket = 1'b0;
  localparam logic CmdTick   = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  ip_protocol;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] packet_length;
  } in_req_t;

  typedef struct packed {
    logic [15:0] flow_source_port;
    logic [15:0] flow_dest_port;
    logic        flow_is_udp;
    logic        attack_label;
    logic [31:0] flow_packets;
    logic [23:0] average_length;
    logic        last_record;
  } out_req_t;

  // Classified request passed from the front to the back.
  typedef struct packed {
    logic            tick;
    logic [KeyW-1:0] key;
    logic [15:0]     len;
  } op_t;

endpackage

// ===== rtl/core/ifst_ram.sv =====
module ifst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/ifst_front.sv =====
module ifst_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ifst_pkg::in_req_t in_data_i,
  output logic             op_valid_o,
  input  logic             op_ready_i,
  output ifst_pkg::op_t    op_o
);
  import ifst_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);

  op_t            q_mem_q [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            is_tcp, is_udp, keep, push, pop;
  op_t             op_new;

  // Classify: drop anything that is neither a tick nor TCP/UDP.
  assign is_tcp = in_data_i.ip_protocol == ProtoTcp;
  assign is_udp = in_data_i.ip_protocol == ProtoUdp;
  assign keep   = (in_data_i.cmd == CmdTick) || is_tcp || is_udp;
  assign op_new.tick = in_data_i.cmd == CmdTick;
  assign op_new.key  = {is_udp, in_data_i.source_port, in_data_i.dest_port};
  assign op_new.len  = in_data_i.packet_length;

  assign in_ready_o = cnt_q != (PtrW+1)'(QDepth);
  assign push       = in_valid_i && in_ready_o && keep;
  assign op_valid_o = cnt_q != '0;
  assign pop        = op_valid_o && op_ready_i;
  assign op_o       = q_mem_q[rd_q];

  // Short queue between the front and the back.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_q] <= op_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

endmodule

// ===== rtl/core/ifst_div.sv =====
module ifst_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [ifst_pkg::ByteW-1:0] bytes_i,
  input  logic [ifst_pkg::PktW-1:0]  pkts_i,
  output logic                     busy_o,
  output logic [ifst_pkg::AvgW-1:0]  avg_o
);
  import ifst_pkg::*;

  // Dividend is bytes << 8; one quotient bit per cycle.
  localparam int unsigned DvdW = ByteW + 8;
  localparam int unsigned StepW = $clog2(DvdW + 1);

  logic [DvdW-1:0]  dvd_q, dvd_d;
  logic [PktW:0]    rem_q, rem_d, trial;
  logic [PktW-1:0]  dvs_q;
  logic [DvdW-1:0]  quo_q, quo_d;
  logic [StepW-1:0] step_q;
  logic             bit_ok;

  assign trial  = {rem_q[PktW-1:0], dvd_q[DvdW-1]};
  assign bit_ok = trial >= {1'b0, dvs_q};
  assign rem_d  = bit_ok ? trial - {1'b0, dvs_q} : trial;
  assign dvd_d  = {dvd_q[DvdW-2:0], 1'b0};
  assign quo_d  = {quo_q[DvdW-2:0], bit_ok};
  assign busy_o = step_q != '0;
  // Saturate the quotient at the top of the 16.8 range.
  assign avg_o  = (quo_q[DvdW-1:AvgW] != '0) ? '1 : quo_q[AvgW-1:0];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {bytes_i, 8'd0};
      dvs_q <= pkts_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_o) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (start_i) begin
      step_q <= StepW'(DvdW);
    end else if (busy_o) begin
      step_q <= step_q - 1'b1;
    end
  end

endmodule

// ===== rtl/core/ifst_back.sv =====
module ifst_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              op_valid_i,
  output logic              op_ready_o,
  input  ifst_pkg::op_t     op_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ifst_pkg::out_req_t out_data_o
);
  import ifst_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StUpd  = 3'd2;
  localparam logic [2:0] StDump = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0]      st_q, st_d;
  logic [CntW-1:0] fill_q, fill_d, idx_q, idx_d;
  op_t             op_q;
  logic            rd_wait_q, rd_wait_d;
  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  logic [RowW-1:0] wdata, rdata;
  logic [KeyW-1:0] r_key;
  logic [PktW-1:0] r_pkt;
  logic [ByteW-1:0] r_byte;
  logic [ByteW:0]  bsum;
  logic            div_start, div_busy;
  logic [AvgW-1:0] div_avg;
  out_req_t        out_q, out_d;
  logic            out_v_q, out_v_d;

  assign {r_key, r_pkt, r_byte} = rdata;
  assign bsum = {1'b0, r_byte} + {{(ByteW-16+1){1'b0}}, op_q.len};

  ifst_ram #(.Width(RowW), .Depth(FlowEntries)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ifst_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .bytes_i (r_byte),
    .pkts_i  (r_pkt),
    .busy_o  (div_busy),
    .avg_o   (div_avg)
  );

  assign op_ready_o  = st_q == StIdle;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;
  assign raddr       = idx_d[IdxW-1:0];

  // Sequencer: linear key scan for packets, record walk for ticks.
  always_comb begin
    st_d      = st_q;
    fill_d    = fill_q;
    idx_d     = idx_q;
    rd_wait_d = 1'b0;
    we        = 1'b0;
    waddr     = idx_q[IdxW-1:0];
    wdata     = {op_q.key, PktW'(1), ByteW'(op_q.len)};
    div_start = 1'b0;
    out_d     = out_q;
    out_v_d   = out_v_q && !out_ready_i;
    unique case (st_q)
      StIdle: begin
        if (op_valid_i) begin
          idx_d = '0;
          if (fill_q == '0) begin
            if (!op_i.tick) begin
              st_d = StUpd;
            end
          end else begin
            rd_wait_d = 1'b1;
            st_d = op_i.tick ? StDump : StScan;
          end
        end
      end
      StScan: begin
        if (rd_wait_q) begin
          // Wait state after each new read address; rdata already holds row idx_q.
        end else if (r_key == op_q.key) begin
          we    = 1'b1;
          wdata = {r_key, (r_pkt == '1) ? r_pkt : r_pkt + 1'b1,
                   bsum[ByteW] ? {ByteW{1'b1}} : bsum[ByteW-1:0]};
          st_d  = StIdle;
        end else if (idx_q + 1'b1 == fill_q) begin
          idx_d = fill_q;
          st_d  = StUpd;
        end else begin
          idx_d     = idx_q + 1'b1;
          rd_wait_d = 1'b1;
        end
      end
      StUpd: begin
        // New flow goes into the next free row when there is room.
        if (fill_q != CntW'(FlowEntries)) begin
          we     = 1'b1;
          waddr  = fill_q[IdxW-1:0];
          fill_d = fill_q + 1'b1;
        end
        st_d = StIdle;
      end
      StDump: begin
        // The previous record must leave before its fields are replaced.
        if (!rd_wait_q && !out_v_q) begin
          div_start = 1'b1;
          out_d.flow_source_port = r_key[31:16];
          out_d.flow_dest_port   = r_key[15:0];
          out_d.flow_is_udp      = r_key[32];
          out_d.attack_label     = r_key[32];
          out_d.flow_packets     = r_pkt;
          out_d.last_record      = idx_q + 1'b1 == fill_q;
          st_d = StDiv;
        end
      end
      StDiv: begin
        if (!div_busy && !out_v_q) begin
          out_d.average_length = div_avg;
          out_v_d = 1'b1;
          st_d    = StOut;
        end
      end
      StOut: begin
        if (out_q.last_record) begin
          fill_d = '0;
          st_d   = StIdle;
        end else begin
          idx_d     = idx_q + 1'b1;
          rd_wait_d = 1'b1;
          st_d      = StDump;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && op_valid_i) begin
      op_q <= op_i;
    end
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StIdle;
      fill_q    <= '0;
      idx_q     <= '0;
      rd_wait_q <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      st_q      <= st_d;
      fill_q    <= fill_d;
      idx_q     <= idx_d;
      rd_wait_q <= rd_wait_d;
      out_v_q   <= out_v_d;
    end
  end

endmodule

// ===== rtl/core/interval_flow_statistics_table.sv =====
// Channel | Signals                        | Payload
// in      | in_valid_i / in_ready_o        | in_data_i  (ifst_pkg::in_req_t)
// out     | out_valid_o / out_ready_i      | out_data_o (ifst_pkg::out_req_t)
//
// A packet request holds the back end for a linear key scan over the
// one-read-port flow RAM, a read and a compare per live flow, ending early on a
// hit; the front queue registers each request before the back end sees it.
// A tick walks the records one at a time through the bit-serial divider, and a
// record waiting on out_ready_i holds the walk before the next record.
// Reset clears the fill count but not the RAM rows; rows are read only below it.
// The front queue holds two requests, so input stalls only when it is full.
module interval_flow_statistics_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ifst_pkg::in_req_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ifst_pkg::out_req_t out_data_o
);
  import ifst_pkg::*;

  logic op_valid, op_ready;
  op_t  op;

  ifst_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .op_valid_o (op_valid),
    .op_ready_i (op_ready),
    .op_o       (op)
  );

  ifst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_ready_o  (op_ready),
    .op_i        (op),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
